// ===== hw/rtl/scca_pkg.sv =====
// shared types and constants for the size-class chunk allocator
`default_nettype none

package scca_pkg;

  localparam int KIND_W = 2;
  localparam int SIZE_W = 29;
  localparam int ADDR_W = 34;
  localparam int STAT_W = 3;
  localparam int CLS_W  = 5;
  localparam int PW     = 33;

  localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESIZE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK          = 3'd0;
  localparam logic [STAT_W-1:0] STAT_TOO_LARGE   = 3'd1;
  localparam logic [STAT_W-1:0] STAT_REGION_FULL = 3'd2;
  localparam logic [STAT_W-1:0] STAT_STACK_FULL  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_BAD_ADDR    = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OLD,
    ST_DEC,
    ST_WB
  } state_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              commit;
    logic              pop;
    logic              push;
    logic              keep;
    logic              copy;
  } dec_t;

endpackage

`default_nettype wire

// ===== hw/rtl/scca_ram.sv =====
// generic single-clock ram, one write port and one registered read port
`default_nettype none

module scca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/size_class_chunk_allocator.sv =====
// power-of-two size-class chunk allocator, top level
`default_nettype none

// A request runs through the states ST_OLD, ST_DEC and ST_WB before the next start can be taken: the
// class counters and bump pointers sit in one small ram that is read for the old class and
// then the new class, followed by the free-stack read and the write-back. busy is
// high from a start transfer through the write-back state; the result is on the out_ ports, marked by
// out_valid, for one cycle right after busy falls, and must be taken then since the
// receiver cannot stall it. The class table starts out as all zero through per-class valid
// bits, so no clearing pass is needed after reset.
module size_class_chunk_allocator #(
  parameter int REGION_SHIFT = 29,
  parameter int CLASS_COUNT  = 29,
  parameter int MIN_CLASS    = 3,
  parameter int FREE_DEPTH   = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [scca_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [scca_pkg::SIZE_W-1:0]   in_req_size,
  input  wire logic [scca_pkg::ADDR_W-1:0]   in_chunk_addr,
  output logic                               out_valid,
  output logic      [scca_pkg::ADDR_W-1:0]   out_result_addr,
  output logic      [scca_pkg::STAT_W-1:0]   out_status,
  output logic                               out_copy_needed,
  output logic      [scca_pkg::SIZE_W-1:0]   out_copy_length
);

  import scca_pkg::*;

  localparam int NUM_CLS = CLASS_COUNT - MIN_CLASS;
  localparam int KIW     = (NUM_CLS > 1) ? $clog2(NUM_CLS) : 1;
  localparam int CNTW    = $clog2(FREE_DEPTH + 1);
  localparam int OFFW    = REGION_SHIFT;
  localparam int BW      = REGION_SHIFT + 1;
  localparam int CLW     = ADDR_W - REGION_SHIFT;
  localparam int SDEPTH  = NUM_CLS * FREE_DEPTH;
  localparam int SAW     = $clog2(SDEPTH);

  typedef struct packed {
    logic [CNTW-1:0] cnt;
    logic [BW-1:0]   bump;
  } meta_t;

  state_t state_r, state_nxt;

  // request fields decoded at the start transfer
  logic [KIND_W-1:0] kind_r;
  logic [ADDR_W-1:0] addr_r;
  logic              addr_nz_r;
  logic [CLS_W-1:0]  ncls_r;
  logic [KIW-1:0]    nidx_r;
  logic              oversize_r;
  logic [CLS_W-1:0]  ocls_r;
  logic [KIW-1:0]    oidx_r;
  logic              ook_r;
  logic              misal_r;
  logic              fits_r;
  logic [OFFW-1:0]   ooff_r;
  logic [CNTW-1:0]   o_cnt_r;
  logic [BW-1:0]     o_bump_r;
  logic [OFFW-1:0]   res_off_r;
  dec_t              dec_r;

  logic [SIZE_W-1:0] sm1;
  logic [CLS_W-1:0]  lg;
  logic [CLS_W-1:0]  ncls;
  logic              oversize;
  logic [KIW-1:0]    nidx;
  logic [CLW-1:0]    ocls_full;
  logic [CLS_W-1:0]  ocls;
  logic              ook;
  logic [KIW-1:0]    oidx;
  logic [OFFW-1:0]   ooff;
  logic              misal;
  logic              fits;

  // class table ram
  logic [NUM_CLS-1:0] cls_vld_r;
  logic               meta_rvld_r;
  logic               meta_we;
  logic [KIW-1:0]     meta_waddr;
  meta_t              meta_wdata;
  logic [KIW-1:0]     meta_raddr;
  meta_t              meta_rdata;
  meta_t              n_meta;

  // free-stack ram
  logic               stk_we;
  logic [SAW-1:0]     stk_waddr;
  logic [OFFW-1:0]    stk_wdata;
  logic [SAW-1:0]     stk_raddr;
  logic [OFFW-1:0]    stk_rdata;

  logic [PW-1:0]      pw_n;
  logic [PW-1:0]      room;
  logic               addr_bad;
  logic               o_full;
  logic [STAT_W-1:0]  alloc_st;
  dec_t               dec;
  logic [SAW-1:0]     nbase;
  logic [SAW-1:0]     obase;
  logic [OFFW-1:0]    res_off;

  logic               out_valid_r;
  logic [ADDR_W-1:0]  out_result_addr_r;
  logic [STAT_W-1:0]  out_status_r;
  logic               out_copy_needed_r;
  logic [SIZE_W-1:0]  out_copy_length_r;

  logic               accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // size class and address decode on the input ports
  always_comb begin
    sm1 = in_req_size - SIZE_W'(1);
    lg  = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (sm1[i]) begin
        lg = CLS_W'(i + 1);
      end
    end
    if (in_req_size <= SIZE_W'(1)) begin
      lg = '0;
    end
    ncls     = (lg < CLS_W'(MIN_CLASS)) ? CLS_W'(MIN_CLASS) : lg;
    oversize = (ncls > CLS_W'(CLASS_COUNT - 1));
    nidx     = oversize ? '0 : KIW'(ncls - CLS_W'(MIN_CLASS));

    ocls_full = in_chunk_addr[ADDR_W-1:REGION_SHIFT];
    ook       = (32'(ocls_full) >= 32'(MIN_CLASS)) && (32'(ocls_full) < 32'(CLASS_COUNT));
    ocls      = CLS_W'(ocls_full);
    oidx      = ook ? KIW'(ocls - CLS_W'(MIN_CLASS)) : '0;
    ooff      = in_chunk_addr[OFFW-1:0];
    misal     = 1'b0;
    for (int i = 0; i < OFFW; i++) begin
      if (ooff[i] && (i < int'(ocls))) begin
        misal = 1'b1;
      end
    end
    fits = ({{(PW-SIZE_W){1'b0}}, in_req_size} <= (PW'(1) << ocls));
  end

  // decision on the class table contents
  always_comb begin
    n_meta   = meta_rvld_r ? meta_rdata : '0;
    pw_n     = PW'(1) << ncls_r;
    room     = (PW'(1) << REGION_SHIFT) - PW'(n_meta.bump);
    addr_bad = !ook_r || misal_r || (BW'(ooff_r) >= o_bump_r);
    o_full   = (o_cnt_r >= CNTW'(FREE_DEPTH));
    if (oversize_r) begin
      alloc_st = STAT_TOO_LARGE;
    end else if ((n_meta.cnt == '0) && (pw_n > room)) begin
      alloc_st = STAT_REGION_FULL;
    end else begin
      alloc_st = STAT_OK;
    end

    dec = '0;
    unique case (kind_r)
      KIND_ALLOC: begin
        dec.status = alloc_st;
        dec.commit = (alloc_st == STAT_OK);
      end
      KIND_FREE: begin
        if (addr_nz_r) begin
          priority if (addr_bad) begin
            dec.status = STAT_BAD_ADDR;
          end else if (o_full) begin
            dec.status = STAT_STACK_FULL;
          end else begin
            dec.push = 1'b1;
          end
        end
      end
      KIND_RESIZE: begin
        priority if (addr_nz_r && addr_bad) begin
          dec.status = STAT_BAD_ADDR;
        end else if (addr_nz_r && fits_r) begin
          dec.keep = 1'b1;
        end else begin
          dec.status = alloc_st;
          if ((alloc_st == STAT_OK) && addr_nz_r && o_full) begin
            dec.status = STAT_STACK_FULL;
          end
          if (dec.status == STAT_OK) begin
            dec.commit = 1'b1;
            dec.push   = addr_nz_r;
            dec.copy   = addr_nz_r;
          end
        end
      end
      default: begin
        dec = '0;
      end
    endcase
    dec.pop = dec.commit && (n_meta.cnt != '0);

    nbase   = SAW'(nidx_r) * SAW'(FREE_DEPTH);
    obase   = SAW'(oidx_r) * SAW'(FREE_DEPTH);
    res_off = dec_r.pop ? stk_rdata : res_off_r;
  end

  // state machine and ram control
  always_comb begin
    state_nxt  = state_r;
    meta_raddr = nidx_r;
    meta_we    = 1'b0;
    meta_waddr = nidx_r;
    meta_wdata = '0;
    stk_we     = 1'b0;
    stk_waddr  = obase + SAW'(o_cnt_r);
    stk_wdata  = ooff_r;
    stk_raddr  = nbase + SAW'(n_meta.cnt - CNTW'(1));
    unique case (state_r)
      ST_IDLE: begin
        meta_raddr = oidx;
        if (accept) begin
          state_nxt = ST_OLD;
        end
      end
      ST_OLD: begin
        meta_raddr = nidx_r;
        state_nxt  = ST_DEC;
      end
      ST_DEC: begin
        meta_we    = dec.commit;
        meta_waddr = nidx_r;
        meta_wdata.cnt  = dec.pop ? (n_meta.cnt - CNTW'(1)) : n_meta.cnt;
        meta_wdata.bump = dec.pop ? n_meta.bump : (n_meta.bump + BW'(pw_n));
        state_nxt  = ST_WB;
      end
      ST_WB: begin
        meta_we         = dec_r.push;
        meta_waddr      = oidx_r;
        meta_wdata.cnt  = o_cnt_r + CNTW'(1);
        meta_wdata.bump = o_bump_r;
        stk_we          = dec_r.push;
        state_nxt       = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cls_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_WB);
      if (meta_we) begin
        cls_vld_r[meta_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    meta_rvld_r <= cls_vld_r[meta_raddr];
    if (accept) begin
      kind_r     <= in_kind;
      addr_r     <= in_chunk_addr;
      addr_nz_r  <= (in_chunk_addr != '0);
      ncls_r     <= ncls;
      nidx_r     <= nidx;
      oversize_r <= oversize;
      ocls_r     <= ocls;
      oidx_r     <= oidx;
      ook_r      <= ook;
      misal_r    <= misal;
      fits_r     <= fits;
      ooff_r     <= ooff;
    end
    if (state_r == ST_OLD) begin
      o_cnt_r  <= n_meta.cnt;
      o_bump_r <= n_meta.bump;
    end
    if (state_r == ST_DEC) begin
      dec_r     <= dec;
      res_off_r <= n_meta.bump[OFFW-1:0];
    end
    if (state_r == ST_WB) begin
      out_status_r      <= dec_r.status;
      out_copy_needed_r <= dec_r.copy;
      out_copy_length_r <= dec_r.copy ? SIZE_W'(PW'(1) << ocls_r) : '0;
      if (dec_r.commit) begin
        out_result_addr_r <= (ADDR_W'(ncls_r) << REGION_SHIFT) | ADDR_W'(res_off);
      end else if (dec_r.keep) begin
        out_result_addr_r <= addr_r;
      end else begin
        out_result_addr_r <= '0;
      end
    end
  end

  scca_ram #(
    .WIDTH ($bits(meta_t)),
    .DEPTH (NUM_CLS)
  ) u_meta_ram (
    .clk     (clk),
    .wr_en   (meta_we),
    .wr_addr (meta_waddr),
    .wr_data (meta_wdata),
    .rd_addr (meta_raddr),
    .rd_data (meta_rdata)
  );

  scca_ram #(
    .WIDTH (OFFW),
    .DEPTH (SDEPTH)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (stk_waddr),
    .wr_data (stk_wdata),
    .rd_addr (stk_raddr),
    .rd_data (stk_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_result_addr = out_result_addr_r;
  assign out_status      = out_status_r;
  assign out_copy_needed = out_copy_needed_r;
  assign out_copy_length = out_copy_length_r;

endmodule

`default_nettype wire

// ===== dv/size_class_chunk_allocator_test.sv =====
// testbench for the size-class chunk allocator: predicted grants checked per transfer
`timescale 1ns / 100ps

module size_class_chunk_allocator_test;
  import scca_pkg::*;

  localparam int REGION_SHIFT = 29;
  localparam int CLASS_COUNT  = 29;
  localparam int MIN_CLASS    = 3;
  localparam int FREE_DEPTH   = 1024;
  localparam int NUM_CLS      = CLASS_COUNT - MIN_CLASS;
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [STAT_W-1:0] status;
    logic              copy;
    logic [SIZE_W-1:0] len;
  } grant_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic [KIND_W-1:0] in_kind = '0;
  logic [SIZE_W-1:0] in_req_size = '0;
  logic [ADDR_W-1:0] in_chunk_addr = '0;
  logic              busy;
  logic              out_valid;
  logic [ADDR_W-1:0] out_result_addr;
  logic [STAT_W-1:0] out_status;
  logic              out_copy_needed;
  logic [SIZE_W-1:0] out_copy_length;

  // predictor state
  logic [SIZE_W-1:0] free_offsets [0:NUM_CLS*FREE_DEPTH-1];
  logic [10:0]       free_count   [0:NUM_CLS-1];
  logic [29:0]       carve_ptr    [0:NUM_CLS-1];

  grant_t            expected_grants [$];
  logic [ADDR_W-1:0] live_chunks [$];
  int                errors = 0;
  int                cycle_count = 0;
  int                sender_idle_pct = 0;

  size_class_chunk_allocator #(
    .REGION_SHIFT(REGION_SHIFT),
    .CLASS_COUNT (CLASS_COUNT),
    .MIN_CLASS   (MIN_CLASS),
    .FREE_DEPTH  (FREE_DEPTH)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_req_size    (in_req_size),
    .in_chunk_addr  (in_chunk_addr),
    .out_valid      (out_valid),
    .out_result_addr(out_result_addr),
    .out_status     (out_status),
    .out_copy_needed(out_copy_needed),
    .out_copy_length(out_copy_length)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [ADDR_W-1:0] chunk_at(input int c, input logic [SIZE_W-1:0] off);
    return {c[4:0], off};
  endfunction

  function automatic int class_for_size(input logic [SIZE_W-1:0] size);
    int          c;
    logic [63:0] size64;
    size64 = {35'd0, size};
    c = MIN_CLASS;
    while (c < 40 && (64'd1 << c) < size64) c++;
    return c;
  endfunction

  function automatic bit region_has_room(input int c);
    int k;
    k = c - MIN_CLASS;
    if (free_count[k] != 0) return 1'b1;
    return (64'd1 << c) <= ((64'd1 << REGION_SHIFT) - {34'd0, carve_ptr[k]});
  endfunction

  function automatic logic [ADDR_W-1:0] take_chunk(input int c);
    int                k;
    logic [SIZE_W-1:0] off;
    k = c - MIN_CLASS;
    if (free_count[k] != 0) begin
      free_count[k] = free_count[k] - 11'd1;
      off = free_offsets[k*FREE_DEPTH + int'(free_count[k])];
    end else begin
      off = carve_ptr[k][SIZE_W-1:0];
      carve_ptr[k] = carve_ptr[k] + (30'd1 << c);
    end
    return chunk_at(c, off);
  endfunction

  function automatic void push_chunk(input int c, input logic [SIZE_W-1:0] off);
    int k;
    k = c - MIN_CLASS;
    free_offsets[k*FREE_DEPTH + int'(free_count[k])] = off;
    free_count[k] = free_count[k] + 11'd1;
  endfunction

  function automatic logic [STAT_W-1:0] check_chunk(input logic [ADDR_W-1:0] a);
    int                c;
    logic [SIZE_W-1:0] o;
    c = int'(a[ADDR_W-1:REGION_SHIFT]);
    o = a[REGION_SHIFT-1:0];
    if (c < MIN_CLASS || c >= CLASS_COUNT) return STAT_BAD_ADDR;
    if ((o & ((29'd1 << c) - 29'd1)) != '0) return STAT_BAD_ADDR;
    if ({1'b0, o} >= carve_ptr[c - MIN_CLASS]) return STAT_BAD_ADDR;
    return STAT_OK;
  endfunction

  task automatic predict_grant(input logic [KIND_W-1:0] kind, input logic [SIZE_W-1:0] size,
                               input logic [ADDR_W-1:0] addr, output grant_t g);
    int                nc;
    int                oc;
    logic [63:0]       size64;
    logic [63:0]       old_span;
    logic [STAT_W-1:0] st;
    bit                have_old;
    g = '0;
    st = STAT_OK;
    size64 = {35'd0, size};
    nc = class_for_size(size);
    oc = int'(addr[ADDR_W-1:REGION_SHIFT]);
    old_span = 64'd1 << oc;
    have_old = (addr != '0);
    case (kind)
      KIND_ALLOC: begin
        if (nc > CLASS_COUNT - 1) st = STAT_TOO_LARGE;
        else if (!region_has_room(nc)) st = STAT_REGION_FULL;
        else g.addr = take_chunk(nc);
      end
      KIND_FREE: begin
        if (have_old) begin
          st = check_chunk(addr);
          if (st == STAT_OK && free_count[oc - MIN_CLASS] >= FREE_DEPTH) st = STAT_STACK_FULL;
          if (st == STAT_OK) push_chunk(oc, addr[REGION_SHIFT-1:0]);
        end
      end
      KIND_RESIZE: begin
        if (have_old) st = check_chunk(addr);
        if (st == STAT_OK && have_old && size64 <= old_span) begin
          g.addr = addr;
        end else if (st == STAT_OK) begin
          if (nc > CLASS_COUNT - 1) st = STAT_TOO_LARGE;
          else if (!region_has_room(nc)) st = STAT_REGION_FULL;
          else if (have_old && free_count[oc - MIN_CLASS] >= FREE_DEPTH) st = STAT_STACK_FULL;
          if (st == STAT_OK) begin
            g.addr = take_chunk(nc);
            if (have_old) begin
              push_chunk(oc, addr[REGION_SHIFT-1:0]);
              g.copy = 1'b1;
              g.len = old_span[SIZE_W-1:0];
            end
          end
        end
      end
      default: ;
    endcase
    g.status = st;
  endtask

  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [SIZE_W-1:0] size,
                              input logic [ADDR_W-1:0] addr, output grant_t g);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_kind <= kind;
    in_req_size <= size;
    in_chunk_addr <= addr;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predict_grant(kind, size, addr, g);
    expected_grants.push_back(g);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic compare_field(input string label, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    grant_t want;
    if (rst_n && out_valid) begin
      if (expected_grants.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer, expected none actual addr %h status %0d",
                 $time, out_result_addr, out_status);
      end else begin
        want = expected_grants.pop_front();
        compare_field("result_addr", 64'(want.addr), 64'(out_result_addr));
        compare_field("status", 64'(want.status), 64'(out_status));
        compare_field("copy_needed", 64'(want.copy), 64'(out_copy_needed));
        compare_field("copy_length", 64'(want.len), 64'(out_copy_length));
      end
    end
  end

  function automatic logic [SIZE_W-1:0] random_size();
    int          c;
    int unsigned lo;
    int unsigned hi;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) c = $urandom_range(12, MIN_CLASS);
    else if (r < 90) c = $urandom_range(20, 13);
    else c = $urandom_range(CLASS_COUNT - 1, 21);
    hi = 32'd1 << c;
    lo = (c == MIN_CLASS) ? 32'd0 : (hi >> 1) + 32'd1;
    if ($urandom_range(3) != 0) hi = $urandom_range(hi, lo);
    return hi[SIZE_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] stray_addr();
    int c;
    case ($urandom_range(2))
      0: return chunk_at($urandom_range(CLASS_COUNT - 1, 0), SIZE_W'($urandom));
      1: begin
        c = $urandom_range(CLASS_COUNT - 1, MIN_CLASS);
        return chunk_at(c, carve_ptr[c - MIN_CLASS][SIZE_W-1:0]);
      end
      default: return '0;
    endcase
  endfunction

  task automatic test_alloc_edges();
    grant_t g;
    send_request(KIND_ALLOC, 29'd0, '0, g);
    send_request(KIND_ALLOC, 29'd1, '0, g);
    send_request(KIND_ALLOC, 29'd8, '0, g);
    send_request(KIND_ALLOC, 29'd9, '0, g);
    send_request(KIND_ALLOC, 29'h1000_0000, '0, g);
    send_request(KIND_ALLOC, 29'h1000_0000, '0, g);
    // top class region now exhausted
    send_request(KIND_ALLOC, 29'h1000_0000, '0, g);
    send_request(KIND_ALLOC, 29'h1000_0001, '0, g);
    send_request(KIND_ALLOC, 29'h1FFF_FFFF, '0, g);
  endtask

  task automatic test_free_checks();
    grant_t g;
    send_request(KIND_FREE, 29'h1FFF_FFFF, '0, g);
    send_request(KIND_FREE, 29'd0, 34'd1, g);
    send_request(KIND_FREE, 29'd0, chunk_at(31, 29'd0), g);
    send_request(KIND_FREE, 29'd0, chunk_at(4, 29'd8), g);
    send_request(KIND_FREE, 29'd0, chunk_at(4, 29'd16), g);
    send_request(KIND_FREE, 29'd0, chunk_at(3, 29'h1FFF_FFF8), g);
    send_request(KIND_FREE, 29'd0, chunk_at(3, 29'd0), g);
    // lifo pop of the chunk just freed
    send_request(KIND_ALLOC, 29'd5, '0, g);
  endtask

  task automatic test_resize_cases();
    grant_t g;
    send_request(KIND_RESIZE, 29'd0, chunk_at(3, 29'd8), g);
    send_request(KIND_RESIZE, 29'd16, chunk_at(4, 29'd0), g);
    send_request(KIND_RESIZE, 29'd100, chunk_at(3, 29'd8), g);
    send_request(KIND_RESIZE, 29'd40, '0, g);
    send_request(KIND_RESIZE, 29'd64, chunk_at(4, 29'd32), g);
    send_request(KIND_RESIZE, 29'h1FFF_FFFF, chunk_at(28, 29'd0), g);
    send_request(KIND_RESIZE, 29'h1000_0000, chunk_at(4, 29'd0), g);
    send_request(KIND_UNUSED, SIZE_W'($urandom), ADDR_W'({$urandom, $urandom}), g);
    send_request(KIND_FREE, 29'd0, chunk_at(28, 29'h1000_0000), g);
    send_request(KIND_RESIZE, 29'h1000_0000, chunk_at(3, 29'd16), g);
    wait_idle();
  endtask

  task automatic test_stack_full();
    grant_t            g;
    logic [ADDR_W-1:0] victim;
    send_request(KIND_ALLOC, 29'h0010_0000, '0, g);
    victim = g.addr;
    // repeated frees of one chunk fill its class stack
    repeat (FREE_DEPTH + 1) send_request(KIND_FREE, SIZE_W'($urandom), victim, g);
    send_request(KIND_RESIZE, 29'h0020_0000, victim, g);
    wait_idle();
  endtask

  task automatic test_random(input int n_items);
    int                op;
    int                idx;
    int                alloc_pct;
    bit                from_live;
    logic [KIND_W-1:0] kind;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    grant_t            g;
    for (int i = 0; i < n_items; i++) begin
      op = $urandom_range(99);
      alloc_pct = (live_chunks.size() > 150) ? 15 : 45;
      from_live = 1'b0;
      addr = '0;
      size = random_size();
      kind = KIND_ALLOC;
      if (op >= alloc_pct && op < 92) begin
        kind = (op < 72) ? KIND_FREE : KIND_RESIZE;
        if (live_chunks.size() != 0 && $urandom_range(9) != 0) begin
          idx = $urandom_range(live_chunks.size() - 1);
          addr = live_chunks[idx];
          live_chunks.delete(idx);
          from_live = 1'b1;
        end else begin
          addr = stray_addr();
        end
      end else if (op >= 92) begin
        case ($urandom_range(3))
          0: size = SIZE_W'($urandom_range(32'h1FFF_FFFF, 32'h1000_0001));
          1: begin
            kind = KIND_FREE;
            addr = stray_addr();
          end
          2: begin
            kind = KIND_RESIZE;
            addr = stray_addr();
          end
          default: begin
            kind = KIND_UNUSED;
            addr = stray_addr();
          end
        endcase
      end
      send_request(kind, size, addr, g);
      if (g.status == STAT_OK && g.addr != '0) live_chunks.push_back(g.addr);
      else if (from_live && kind == KIND_RESIZE) live_chunks.push_back(addr);
    end
  endtask

  initial begin
    for (int k = 0; k < NUM_CLS; k++) begin
      free_count[k] = '0;
      carve_ptr[k] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_idle_pct = 11;
    test_alloc_edges();
    test_free_checks();
    test_resize_cases();
    test_random(300);
    wait_idle();

    sender_idle_pct = 68;
    test_random(300);
    wait_idle();

    sender_idle_pct = 0;
    test_stack_full();
    test_random(250);
    wait_idle();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/scca_pkg.sv
hw/rtl/scca_ram.sv
hw/rtl/size_class_chunk_allocator.sv
dv/size_class_chunk_allocator_test.sv
